/* src/hsie_pkg.sv */
// Shared types, constants and the Exp-Golomb decode helper for the SPS id extractor.
// No dependencies; imported by hsie_core and hevc_sps_id_extractor.
`timescale 1ns / 1ps

package hsie_pkg;

  typedef struct packed {
    logic [7:0] nal_byte;
    logic       unit_start;
  } in_t;

  typedef struct packed {
    logic [3:0] sps_id;
    logic       malformed;
  } out_t;

  localparam logic [15:0] ProfMask      = 16'hAAA8;
  localparam logic [15:0] LevMask       = 16'h5554;
  localparam logic [6:0]  IdxMax        = 7'd127;
  localparam logic [6:0]  NoSubIdIndex  = 7'd15;
  localparam logic [6:0]  FlagsEndIndex = 7'd17;
  localparam logic [6:0]  SubLayerIndex = 7'd2;
  localparam logic [6:0]  FlagHiIndex   = 7'd15;
  localparam logic [6:0]  FlagLoIndex   = 7'd16;
  localparam logic [6:0]  ProfSkip      = 7'd11;
  localparam logic [7:0]  EpbByte       = 8'h03;
  localparam logic [1:0]  ZeroRunMax    = 2'd2;

  // Decodes an unsigned Exp-Golomb code from the top of one byte. A code with
  // four leading zeros takes its last info bit from the next byte as zero.
  function automatic out_t decode_ue(input logic [7:0] b);
    out_t       r;
    logic [4:0] v;
    v = 5'd0;
    r.malformed = 1'b0;
    if (b[7]) begin
      v = 5'd0;
    end else if (b[6]) begin
      v = 5'd1 + {4'd0, b[5]};
    end else if (b[5]) begin
      v = 5'd3 + {3'd0, b[4:3]};
    end else if (b[4]) begin
      v = 5'd7 + {2'd0, b[3:1]};
    end else if (b[3]) begin
      v = 5'd15 + {1'b0, b[2:0], 1'b0};
    end else begin
      r.malformed = 1'b1;
    end
    if (v > 5'd15) begin
      r.malformed = 1'b1;
    end
    r.sps_id = r.malformed ? 4'd0 : v[3:0];
    return r;
  endfunction

endpackage

/* src/hsie_core.sv */
// Per-byte SPS parse state: emulation byte removal, payload counting, flag
// popcount and id decode. Depends on hsie_pkg.
`timescale 1ns / 1ps

module hsie_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  hsie_pkg::in_t word_i,
  output logic          produced_o,
  output hsie_pkg::out_t result_o
);
  import hsie_pkg::*;

  logic [6:0] idx_q, idx_d;
  logic [1:0] zh_q, zh_d;
  logic [2:0] sub_q, sub_d;
  logic [7:0] hi_q, hi_d;
  logic [6:0] idb_q, idb_d;
  logic       fin_q, fin_d;

  logic [6:0] idx_e, idb_e;
  logic [1:0] zh_e;
  logic [2:0] sub_e;
  logic [7:0] hi_e;
  logic       fin_e;
  logic       is_epb;
  logic [15:0] flags;
  logic [2:0] prof, lev;
  logic [7:0] b;

  always_comb begin
    b      = word_i.nal_byte;
    // A unit start restarts the parse before this byte is looked at.
    idx_e  = word_i.unit_start ? 7'd0 : idx_q;
    zh_e   = word_i.unit_start ? 2'd0 : zh_q;
    sub_e  = word_i.unit_start ? 3'd0 : sub_q;
    hi_e   = word_i.unit_start ? 8'd0 : hi_q;
    idb_e  = word_i.unit_start ? NoSubIdIndex : idb_q;
    fin_e  = word_i.unit_start ? 1'b0 : fin_q;

    is_epb = (b == EpbByte) && (zh_e == ZeroRunMax);
    if (b == 8'd0) begin
      zh_d = (zh_e == ZeroRunMax) ? ZeroRunMax : zh_e + 2'd1;
    end else begin
      zh_d = 2'd0;
    end

    flags = {hi_e, b};
    prof  = 3'($countones(flags & ProfMask));
    lev   = 3'($countones(flags & LevMask));

    idx_d      = idx_e;
    sub_d      = sub_e;
    hi_d       = hi_e;
    idb_d      = idb_e;
    fin_d      = fin_e;
    produced_o = 1'b0;
    result_o   = decode_ue(b);

    if (!(is_epb || fin_e)) begin
      if (idx_e == SubLayerIndex) begin
        sub_d = b[3:1];
        idb_d = (b[3:1] != 3'd0) ? FlagsEndIndex : NoSubIdIndex;
      end
      if (sub_d != 3'd0 && idx_e == FlagHiIndex) begin
        hi_d = b;
      end
      if (sub_d != 3'd0 && idx_e == FlagLoIndex) begin
        idb_d = FlagsEndIndex + ProfSkip * {4'd0, prof} + {4'd0, lev};
      end
      if (idx_e == idb_d) begin
        produced_o = 1'b1;
        fin_d      = 1'b1;
      end
      if (idx_e < IdxMax) begin
        idx_d = idx_e + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 7'd0;
      zh_q  <= 2'd0;
      sub_q <= 3'd0;
      hi_q  <= 8'd0;
      idb_q <= NoSubIdIndex;
      fin_q <= 1'b1;
    end else if (fire_i) begin
      idx_q <= idx_d;
      zh_q  <= zh_d;
      sub_q <= sub_d;
      hi_q  <= hi_d;
      idb_q <= idb_d;
      fin_q <= fin_d;
    end
  end

endmodule

/* src/hevc_sps_id_extractor.sv */
// Top level of the H.265 SPS id extractor: input register, parse core and
// output register. Depends on hsie_pkg and hsie_core.
`timescale 1ns / 1ps

// Feed the raw bytes of a NAL unit one word at a time, with unit_start on the
// first byte; emulation prevention bytes are removed inside. The block takes
// one word per cycle with no bubbles while the output is not stalled. The byte
// that carries the Exp-Golomb id is registered in the input register and its
// result word in the result register, at most one per unit. The parse update
// between the input register and the result register sets this rate. Bytes
// after the id, or before any unit start, are consumed silently. Output stall
// backs up into the input register and then into in_stall_o.
module hevc_sps_id_extractor (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  hsie_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output hsie_pkg::out_t out_data_o
);
  import hsie_pkg::*;

  logic  in_valid_q;
  in_t   in_word_q;
  logic  out_valid_q;
  out_t  out_word_q;
  logic  fire;
  logic  produced;
  out_t  result;

  // The parse stage advances when the result register is empty or draining.
  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;

  hsie_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (fire),
    .word_i     (in_word_q),
    .produced_o (produced),
    .result_o   (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (fire) begin
        out_valid_q <= produced;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_word_q <= in_data_i;
    end
    if (fire && produced) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_word_q;

endmodule

/* sim/tb.sv */
// Testbench for hevc_sps_id_extractor: feeds raw SPS NAL units and checks each id word
// against a byte-level predictor kept in a scoreboard class. Depends on hsie_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import hsie_pkg::*;

  // Tracks the parse state byte by byte and queues the id word each unit should produce.
  class sps_id_scoreboard;
    logic [6:0] pay_idx;
    logic [1:0] zero_run;
    logic [2:0] sub_m1;
    logic [7:0] flag_hi;
    logic [6:0] id_idx;
    bit         done;
    out_t       id_q[$];
    int         errors;
    int         n_ids;
    int         n_malformed;
    int         n_dropped;

    function new();
      pay_idx     = '0;
      zero_run    = '0;
      sub_m1      = '0;
      flag_hi     = '0;
      id_idx      = NoSubIdIndex;
      done        = 1'b1;
      errors      = 0;
      n_ids       = 0;
      n_malformed = 0;
      n_dropped   = 0;
    endfunction

    function out_t decode_id(logic [7:0] b);
      out_t        r;
      int          k;
      int unsigned info;
      int unsigned v;
      logic [15:0] w;
      r = '0;
      k = 0;
      while (k < 8 && b[7-k] == 1'b0) k++;
      if (k > 4) begin
        r.malformed = 1'b1;
        return r;
      end
      // A code with four leading zeros reads one bit past this byte, which is taken as zero.
      w    = {b, 8'h00};
      info = (32'(w) >> (15 - 2 * k)) & ((32'd1 << k) - 1);
      v    = (32'd1 << k) - 1 + info;
      if (v > 15) begin
        r.malformed = 1'b1;
      end else begin
        r.sps_id = v[3:0];
      end
      return r;
    endfunction

    function void note_byte(in_t w);
      bit          drop;
      logic [15:0] flags;
      int          skip;
      if (w.unit_start) begin
        pay_idx  = '0;
        zero_run = '0;
        sub_m1   = '0;
        flag_hi  = '0;
        id_idx   = NoSubIdIndex;
        done     = 1'b0;
      end
      drop = (w.nal_byte == EpbByte) && (zero_run == ZeroRunMax);
      if (w.nal_byte == 8'h00) begin
        zero_run = (zero_run == ZeroRunMax) ? ZeroRunMax : zero_run + 2'd1;
      end else begin
        zero_run = '0;
      end
      if (drop) n_dropped++;
      if (drop || done) return;
      if (pay_idx == SubLayerIndex) begin
        sub_m1 = w.nal_byte[3:1];
        id_idx = (sub_m1 != 3'd0) ? FlagsEndIndex : NoSubIdIndex;
      end
      if (sub_m1 != 3'd0 && pay_idx == FlagHiIndex) flag_hi = w.nal_byte;
      if (sub_m1 != 3'd0 && pay_idx == FlagLoIndex) begin
        flags  = {flag_hi, w.nal_byte};
        skip   = 11 * $countones(flags & ProfMask) + $countones(flags & LevMask);
        id_idx = FlagsEndIndex + 7'(skip);
      end
      if (pay_idx == id_idx) begin
        id_q.push_back(decode_id(w.nal_byte));
        done = 1'b1;
      end
      if (pay_idx != IdxMax) pay_idx++;
    endfunction

    function void check_id(out_t got);
      out_t exp;
      if (id_q.size() == 0) begin
        $display("%0t: unexpected id word: sps_id %0d malformed %0b",
                 $time, got.sps_id, got.malformed);
        errors++;
        return;
      end
      exp = id_q.pop_front();
      if (got.sps_id !== exp.sps_id) begin
        $display("%0t: sps_id mismatch: expected %0d, got %0d", $time, exp.sps_id, got.sps_id);
        errors++;
      end
      if (got.malformed !== exp.malformed) begin
        $display("%0t: malformed mismatch: expected %0b, got %0b",
                 $time, exp.malformed, got.malformed);
        errors++;
      end
      n_ids++;
      if (exp.malformed) n_malformed++;
    endfunction

    function int pending();
      return id_q.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  logic in_valid;
  logic in_stall;
  in_t  in_data;
  logic out_valid;
  logic out_stall;
  out_t out_data;

  sps_id_scoreboard sb;
  logic [7:0] unit_q[$];
  bit  quiet;
  bit  hold_req;
  bit  out_taken;
  int  hold_left;
  int  stall_left;
  int  unit_bytes;
  int  units_sent;
  int  units_cut;
  int  backpressure;

  hevc_sps_id_extractor uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("hevc_sps_id_extractor verification failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid) begin
      if (!in_stall) begin
        sb.note_byte(in_data);
      end else begin
        backpressure++;
      end
    end
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_id(out_data);
      out_taken = 1'b1;
    end
  end

  // Receiver: after each taken word it stalls for a drawn number of cycles; a hold
  // request stalls it for a long stretch so that words back up into the block.
  initial begin
    out_stall  = 1'b0;
    out_taken  = 1'b0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 150;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (out_taken) begin
        out_taken  = 1'b0;
        stall_left = quiet ? 0 : $urandom_range(0, 4);
        out_stall  = (stall_left != 0);
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall = (stall_left != 0);
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  function automatic logic [7:0] fill_byte();
    case ($urandom_range(0, 7))
      0, 1, 2: return 8'h00;
      3:       return 8'h03;
      4:       return 8'($urandom_range(1, 2));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] random_code();
    int k;
    k = $urandom_range(0, 8);
    if (k == 8) return 8'h00;
    return (8'h80 >> k) | (8'($urandom) & ((8'h80 >> k) - 8'd1));
  endfunction

  // Lays out the payload of one SPS unit (before emulation prevention) in unit_q.
  function automatic void build_sps(input logic [2:0] sub, input logic [15:0] flags,
                                    input logic [7:0] code, input logic [7:0] hdr0,
                                    input int tail);
    int skip;
    unit_q.delete();
    unit_q.push_back(hdr0);
    unit_q.push_back(8'($urandom));
    unit_q.push_back({4'($urandom), sub, 1'($urandom)});
    repeat (12) unit_q.push_back(fill_byte());
    if (sub != 3'd0) begin
      unit_q.push_back(flags[15:8]);
      unit_q.push_back(flags[7:0]);
      skip = 11 * $countones(flags & ProfMask) + $countones(flags & LevMask);
      repeat (skip) unit_q.push_back(fill_byte());
    end
    unit_q.push_back(code);
    repeat (tail) unit_q.push_back(fill_byte());
  endfunction

  function automatic void build_random_sps();
    logic [2:0]  sub;
    logic [15:0] flags;
    sub = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(1, 7));
    case ($urandom_range(0, 9))
      0:       flags = 16'($urandom);
      1:       flags = 16'hFFFF;
      default: flags = 16'($urandom & $urandom & $urandom);
    endcase
    build_sps(sub, flags, random_code(), fill_byte(), $urandom_range(0, 4));
  endfunction

  task automatic send_word(input logic [7:0] b, input logic s);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = in_t'{nal_byte: b, unit_start: s};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Sends unit_q with emulation prevention applied; a cut position ends the unit early.
  task automatic send_payload(input int cut);
    int zc;
    zc = 0;
    units_sent++;
    if (cut >= 0) units_cut++;
    for (int i = 0; i < unit_q.size(); i++) begin
      if (i == cut) break;
      if (zc >= 2 && unit_q[i] <= 8'h03) begin
        send_word(EpbByte, 1'b0);
        zc = 0;
      end
      send_word(unit_q[i], i == 0);
      zc = (unit_q[i] == 8'h00) ? ((zc >= 2) ? 2 : zc + 1) : 0;
      unit_bytes++;
    end
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  initial begin
    int iter;
    sb           = new();
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    quiet        = 1'b0;
    hold_req     = 1'b0;
    unit_bytes   = 0;
    units_sent   = 0;
    units_cut    = 0;
    backpressure = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Bytes before any unit start are ignored, including a would-be emulation byte.
    send_word(8'h00, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h03, 1'b0);
    send_word(8'hFF, 1'b0);
    build_sps(3'd0, 16'h0000, 8'h80, 8'h42, 0);
    send_payload(-1);
    // Every flag set gives the longest skip; the id uses the spilled bit.
    build_sps(3'd7, 16'hFFFF, 8'h08, 8'h42, 1);
    send_payload(-1);
    // Value above 15.
    build_sps(3'd1, 16'h0000, 8'h0A, 8'h42, 0);
    send_payload(-1);
    // All-zero id byte, then trailing zeros so that the next unit opens on 0x03.
    build_sps(3'd0, 16'h0000, 8'h00, 8'hFF, 0);
    unit_q.push_back(8'h00);
    unit_q.push_back(8'h00);
    send_payload(-1);
    build_sps(3'd0, 16'h0000, 8'h07, 8'h03, 0);
    send_payload(-1);
    build_sps(3'd2, 16'h8004, 8'h1F, 8'h40, 0);
    send_payload(-1);
    build_sps(3'd0, 16'h0000, 8'h40, 8'h42, 0);
    send_payload(8);
    build_sps(3'd4, 16'h2001, 8'h60, 8'h42, 2);
    send_payload(-1);
    wait_drained();

    iter = 0;
    while (unit_bytes < 1750) begin
      iter++;
      quiet = (iter % 20) < 3;
      if (iter == 12) begin
        // Long receiver hold while units keep coming, so the block fills and stalls.
        hold_req = 1'b1;
        repeat (3) begin
          build_sps(3'd0, 16'h0000, random_code(), 8'h42, 0);
          send_payload(-1);
        end
      end
      if (iter % 40 == 0) wait_drained();
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 6)) send_word(fill_byte(), 1'b0);
        end
        1: begin
          build_random_sps();
          send_payload($urandom_range(1, unit_q.size() - 1));
        end
        default: begin
          build_random_sps();
          send_payload(-1);
        end
      endcase
    end

    wait_drained();
    $display("Sent %0d SPS units (%0d cut short) in %0d payload words; %0d emulation bytes dropped.",
             units_sent, units_cut, unit_bytes, sb.n_dropped);
    $display("Checked %0d id words (%0d malformed); input stalled for %0d cycles.",
             sb.n_ids, sb.n_malformed, backpressure);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("hevc_sps_id_extractor verification clean");
    end else begin
      $display("%0t: %0d errors, %0d id words never arrived", $time, sb.errors, sb.pending());
      $display("hevc_sps_id_extractor verification failed");
    end
    $finish;
  end

endmodule
